// ===== sv/fpac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpac_pkg: shared definitions for the adaptive frame pacer
// Widths, constants, action codes, controller states and divider status.
// ----------------------------------------------------------------------------
package fpac_pkg;

    localparam int DATA_W   = 32;
    localparam int PERIOD_W = 10;
    localparam int BIT_W    = $clog2(DATA_W);

    localparam logic [DATA_W-1:0]   FLOOR_MS     = 32'd10;
    localparam logic [DATA_W-1:0]   WINDOW_LIMIT = 32'd4096;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd100;

    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SHIFT = 6'b000010,
        ST_EVAL  = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_MEAN  = 6'b010000,
        ST_DONE  = 6'b100000
    } fpac_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } fpac_div_sts_t;

endpackage

// ===== sv/fpac_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpac_div: radix-2 restoring divider
// One quotient bit per cycle, done is a pulse.
// ----------------------------------------------------------------------------
module fpac_div
    import fpac_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output fpac_div_sts_t     sts,
    output logic [DATA_W-1:0] quotient
);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;
    logic [BIT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DATA_W:0] partial;
    logic [DATA_W:0] trial;
    logic            fits;

    // shift the next dividend bit into the partial remainder and try the divisor
    assign partial = {rem_reg, quo_reg[DATA_W-1]};
    assign trial   = partial - {1'b0, dsr_reg};
    assign fits    = (partial >= {1'b0, dsr_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? trial[DATA_W-1:0] : partial[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BIT_W'(DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/frame_pacer_adaptive_clamp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_pacer_adaptive_clamp: frame pacer with adaptive elapsed-time clamp
// Clamps frame times to a floor and a running mean, reports the wait to fill
// the frame period.
// ----------------------------------------------------------------------------
// One request at a time. A start request goes straight to ST_DONE, which
// moves its result into the output register. An update runs the elapsed
// time, window sum, count and all compares bit-serially, LSB first, then
// ST_EVAL selects the result into registers and ST_DONE moves it to the
// output register. When the window sum passes 4096 the new mean comes from a
// radix-2 divider, one quotient bit a cycle, which ST_DIV waits on before
// ST_MEAN loads the new mean. The next request is taken as soon as the result
// has gone to the output register, whether or not it has been taken
// downstream. A new frame period acts on the wait at once; the mean is
// reloaded from it only on a start.
// ----------------------------------------------------------------------------
module frame_pacer_adaptive_clamp
    import fpac_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PERIOD_W-1:0] cfg_frame_period_ms,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  logic [DATA_W-1:0]   s_now_ms,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [DATA_W-1:0]   m_clamped_elapsed_ms,
    output logic [PERIOD_W-1:0] m_wait_ms
);

    fpac_state_t state_reg, state_next;

    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [DATA_W-1:0]   now_reg, now_next;
    logic [DATA_W-1:0]   last_reg, last_next;
    logic [DATA_W-1:0]   sum_reg, sum_next;
    logic [DATA_W-1:0]   count_reg, count_next;
    logic [DATA_W-1:0]   mean_reg, mean_next;
    logic [DATA_W-1:0]   raw_reg, raw_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;

    logic sub_c_reg, sub_c_next;
    logic add_c_reg, add_c_next;
    logic inc_c_reg, inc_c_next;
    logic lt_floor_reg, lt_floor_next;
    logic gt_mean_reg, gt_mean_next;
    logic p_gt_raw_reg, p_gt_raw_next;
    logic sum_gt_reg, sum_gt_next;
    logic cnt_nz_reg, cnt_nz_next;

    logic [DATA_W-1:0]   res_clamp_reg, res_clamp_next;
    logic [PERIOD_W-1:0] res_wait_reg, res_wait_next;

    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   m_clamp_reg, m_clamp_next;
    logic [PERIOD_W-1:0] m_wait_reg, m_wait_next;

    logic [DATA_W-1:0] period_ext;
    logic              n_b, l_b, s_b, c_b, m_b, p_b, f_b, w_b;
    logic              raw_b, sum_b, cnt_b;
    logic [DATA_W-1:0] clamp_sel;
    logic              wait_ok;

    logic              div_start;
    logic [DATA_W-1:0] div_divisor;
    fpac_div_sts_t     div_sts;
    logic [DATA_W-1:0] div_quo;

    assign period_ext = {{(DATA_W-PERIOD_W){1'b0}}, period_reg};

    // current bit of each serial stream
    assign n_b = now_reg[0];
    assign l_b = last_reg[0];
    assign s_b = sum_reg[0];
    assign c_b = count_reg[0];
    assign m_b = mean_reg[0];
    assign p_b = period_ext[bit_reg];
    assign f_b = FLOOR_MS[bit_reg];
    assign w_b = WINDOW_LIMIT[bit_reg];

    // raw = now - last as now + ~last + 1
    assign raw_b = n_b ^ ~l_b ^ sub_c_reg;
    assign sum_b = s_b ^ raw_b ^ add_c_reg;
    assign cnt_b = c_b ^ inc_c_reg;

    // floor checked first, then the mean as ceiling
    assign clamp_sel = lt_floor_reg ? FLOOR_MS : (gt_mean_reg ? mean_reg : raw_reg);
    // below the floor the clamp is the floor itself, otherwise clamp <= raw
    assign wait_ok   = p_gt_raw_reg && (!lt_floor_reg || (period_ext > FLOOR_MS));

    assign div_start   = (state_reg == ST_EVAL) && sum_gt_reg;
    assign div_divisor = cnt_nz_reg ? count_reg : DATA_W'(1);

    fpac_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (div_divisor),
        .sts      (div_sts),
        .quotient (div_quo)
    );

    always_comb begin
        state_next     = state_reg;
        period_next    = period_reg;
        now_next       = now_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        mean_next      = mean_reg;
        raw_next       = raw_reg;
        bit_next       = bit_reg;
        sub_c_next     = sub_c_reg;
        add_c_next     = add_c_reg;
        inc_c_next     = inc_c_reg;
        lt_floor_next  = lt_floor_reg;
        gt_mean_next   = gt_mean_reg;
        p_gt_raw_next  = p_gt_raw_reg;
        sum_gt_next    = sum_gt_reg;
        cnt_nz_next    = cnt_nz_reg;
        res_clamp_next = res_clamp_reg;
        res_wait_next  = res_wait_reg;
        m_valid_next   = m_valid_reg;
        m_clamp_next   = m_clamp_reg;
        m_wait_next    = m_wait_reg;

        if (cfg_valid) begin
            period_next = cfg_frame_period_ms;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_action == ACT_START) begin
                        last_next      = s_now_ms;
                        sum_next       = '0;
                        count_next     = '0;
                        mean_next      = period_ext;
                        res_clamp_next = '0;
                        res_wait_next  = '0;
                        state_next     = ST_DONE;
                    end else begin
                        now_next      = s_now_ms;
                        bit_next      = '0;
                        sub_c_next    = 1'b1;
                        add_c_next    = 1'b0;
                        inc_c_next    = 1'b1;
                        lt_floor_next = 1'b0;
                        gt_mean_next  = 1'b0;
                        p_gt_raw_next = 1'b0;
                        sum_gt_next   = 1'b0;
                        cnt_nz_next   = 1'b0;
                        state_next    = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                sub_c_next = (n_b & ~l_b) | (n_b & sub_c_reg) | (~l_b & sub_c_reg);
                add_c_next = (s_b & raw_b) | (s_b & add_c_reg) | (raw_b & add_c_reg);
                inc_c_next = c_b & inc_c_reg;
                // LSB-first compares: the highest differing bit decides
                if (f_b != raw_b) begin
                    lt_floor_next = f_b;
                end
                if (raw_b != m_b) begin
                    gt_mean_next = raw_b;
                end
                if (p_b != raw_b) begin
                    p_gt_raw_next = p_b;
                end
                if (sum_b != w_b) begin
                    sum_gt_next = sum_b;
                end
                cnt_nz_next = cnt_nz_reg | cnt_b;
                // last tick is replaced by now as it rotates
                now_next   = {1'b0, now_reg[DATA_W-1:1]};
                last_next  = {n_b, last_reg[DATA_W-1:1]};
                sum_next   = {sum_b, sum_reg[DATA_W-1:1]};
                count_next = {cnt_b, count_reg[DATA_W-1:1]};
                mean_next  = {m_b, mean_reg[DATA_W-1:1]};
                raw_next   = {raw_b, raw_reg[DATA_W-1:1]};
                bit_next   = bit_reg + 1'b1;
                if (bit_reg == BIT_W'(DATA_W - 1)) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                res_clamp_next = clamp_sel;
                res_wait_next  = wait_ok ? (period_reg - clamp_sel[PERIOD_W-1:0]) : '0;
                state_next     = sum_gt_reg ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN: begin
                mean_next  = div_quo + FLOOR_MS;
                sum_next   = '0;
                count_next = '0;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_clamp_next = res_clamp_reg;
                    m_wait_next  = res_wait_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            period_reg  <= PERIOD_RESET;
            last_reg    <= '0;
            sum_reg     <= '0;
            count_reg   <= '0;
            mean_reg    <= DATA_W'(PERIOD_RESET);
            bit_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            period_reg  <= period_next;
            last_reg    <= last_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            mean_reg    <= mean_next;
            bit_reg     <= bit_next;
            m_valid_reg <= m_valid_next;
        end
        now_reg       <= now_next;
        raw_reg       <= raw_next;
        sub_c_reg     <= sub_c_next;
        add_c_reg     <= add_c_next;
        inc_c_reg     <= inc_c_next;
        lt_floor_reg  <= lt_floor_next;
        gt_mean_reg   <= gt_mean_next;
        p_gt_raw_reg  <= p_gt_raw_next;
        sum_gt_reg    <= sum_gt_next;
        cnt_nz_reg    <= cnt_nz_next;
        res_clamp_reg <= res_clamp_next;
        res_wait_reg  <= res_wait_next;
        m_clamp_reg   <= m_clamp_next;
        m_wait_reg    <= m_wait_next;
    end

    assign cfg_ready            = 1'b1;
    assign s_ready              = (state_reg == ST_IDLE);
    assign m_valid              = m_valid_reg;
    assign m_clamped_elapsed_ms = m_clamp_reg;
    assign m_wait_ms            = m_wait_reg;

endmodule

// ===== sv/fpac_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpac_checker: port-level checks for the adaptive frame pacer
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module fpac_checker
    import fpac_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [DATA_W-1:0]   m_clamped_elapsed_ms,
    input logic [PERIOD_W-1:0] m_wait_ms
);

    // one request in flight: no acceptance in the cycle after one
    property p_one_in_flight;
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready;
    endproperty
    a_one_in_flight: assert property (p_one_in_flight)
        else $error("request accepted while previous one still in work");

    // a result waiting downstream stays put
    property p_result_held;
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_clamped_elapsed_ms)
                                   && $stable(m_wait_ms));
    endproperty
    a_result_held: assert property (p_result_held)
        else $error("stalled result changed or dropped");

    // a non-zero wait implies the clamped time fits within PERIOD_W bits
    property p_wait_bound;
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_wait_ms != '0)) |-> (m_clamped_elapsed_ms[DATA_W-1:PERIOD_W] == '0);
    endproperty
    a_wait_bound: assert property (p_wait_bound)
        else $error("wait given with clamped time beyond the period range");

    // reset leaves the block ready and with no result
    property p_reset_state;
        @(posedge aclk)
        !aresetn |=> (s_ready && !m_valid);
    endproperty
    a_reset_state: assert property (p_reset_state)
        else $error("block not idle after reset");

endmodule

bind frame_pacer_adaptive_clamp fpac_checker u_fpac_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .s_valid              (s_valid),
    .s_ready              (s_ready),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_clamped_elapsed_ms (m_clamped_elapsed_ms),
    .m_wait_ms            (m_wait_ms)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the adaptive frame pacer
// Runs a table of hand-picked requests across several frame periods, then
// long randomised pacing runs. Each result is compared with its table value
// if given, else a cycle-free model of the clamp, the window mean and the wait.
// ----------------------------------------------------------------------------
module tb_top;
    import fpac_pkg::*;

    localparam int RANDOM_FRAMES = 900;
    localparam int CALM_FRAMES   = 100;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        logic [DATA_W-1:0]   clamped;
        logic [PERIOD_W-1:0] pause;
    } frame_result_t;

    typedef struct {
        bit                  is_cfg;
        logic [PERIOD_W-1:0] period;
        logic                act;
        logic [DATA_W-1:0]   now;
        bit                  known;
        frame_result_t       res;
    } plan_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [PERIOD_W-1:0] cfg_frame_period_ms = PERIOD_RESET;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_action = ACT_START;
    logic [DATA_W-1:0]   s_now_ms = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [DATA_W-1:0]   m_clamped_elapsed_ms;
    logic [PERIOD_W-1:0] m_wait_ms;

    // pacer state as the block should hold it
    logic [PERIOD_W-1:0] period_ms    = PERIOD_RESET;
    logic [DATA_W-1:0]   tick_last    = '0;
    logic [DATA_W-1:0]   elapsed_sum  = '0;
    logic [DATA_W-1:0]   frame_count  = '0;
    logic [DATA_W-1:0]   mean_ceiling = {22'd0, PERIOD_RESET};

    frame_result_t frame_results_due[$];
    frame_result_t due_now;
    plan_row_t     pacing_plan[$];

    int  mismatches  = 0;
    int  cycle_count = 0;
    int  stall_pct   = 30;
    int  stall_left  = 0;
    bit  calm        = 1'b0;

    frame_pacer_adaptive_clamp dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_frame_period_ms  (cfg_frame_period_ms),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_action             (s_action),
        .s_now_ms             (s_now_ms),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_clamped_elapsed_ms (m_clamped_elapsed_ms),
        .m_wait_ms            (m_wait_ms)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t ns mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic pace_frame(input logic act, input logic [DATA_W-1:0] now,
                              output frame_result_t res);
        logic [DATA_W-1:0] raw;
        logic [DATA_W-1:0] clamp;
        logic [DATA_W-1:0] divisor;
        logic [DATA_W-1:0] period_w;
        period_w = {{(DATA_W-PERIOD_W){1'b0}}, period_ms};
        res = '0;
        if (act == ACT_START) begin
            tick_last    = now;
            elapsed_sum  = '0;
            frame_count  = '0;
            mean_ceiling = period_w;
        end else begin
            raw = now - tick_last;
            elapsed_sum = elapsed_sum + raw;
            frame_count = frame_count + 1;
            // floor wins over the ceiling
            if (raw < FLOOR_MS)
                clamp = FLOOR_MS;
            else if (raw > mean_ceiling)
                clamp = mean_ceiling;
            else
                clamp = raw;
            if (elapsed_sum > WINDOW_LIMIT) begin
                divisor = (frame_count == 0) ? 1 : frame_count;
                mean_ceiling = elapsed_sum / divisor + FLOOR_MS;
                elapsed_sum  = '0;
                frame_count  = '0;
            end
            tick_last   = now;
            res.clamped = clamp;
            if (period_w > raw && period_w > clamp)
                res.pause = PERIOD_W'(period_w - clamp);
        end
    endtask

    task automatic plan_period(input logic [PERIOD_W-1:0] p);
        plan_row_t row;
        row = '{is_cfg: 1'b1, period: p, act: ACT_START, now: '0, known: 1'b0, res: '0};
        pacing_plan.push_back(row);
    endtask

    task automatic plan_frame(input logic act, input logic [DATA_W-1:0] now);
        plan_row_t row;
        row = '{is_cfg: 1'b0, period: '0, act: act, now: now, known: 1'b0, res: '0};
        pacing_plan.push_back(row);
    endtask

    task automatic plan_known(input logic act, input logic [DATA_W-1:0] now,
                              input logic [DATA_W-1:0] clamp,
                              input logic [PERIOD_W-1:0] pause);
        plan_row_t row;
        row = '{is_cfg: 1'b0, period: '0, act: act, now: now, known: 1'b1,
                res: '{clamped: clamp, pause: pause}};
        pacing_plan.push_back(row);
    endtask

    task automatic send_frame(input logic act, input logic [DATA_W-1:0] now,
                              input bit known, input frame_result_t known_res);
        frame_result_t res;
        if (!calm && $urandom_range(0, 99) < stall_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_now_ms <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pace_frame(act, now, res);
        frame_results_due.push_back(known ? known_res : res);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (frame_results_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] p);
        cfg_valid           <= 1'b1;
        cfg_frame_period_ms <= p;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        period_ms = p;
    endtask

    function automatic logic [DATA_W-1:0] frame_step();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 5)
            return $urandom_range(0, 12);
        else if (r < 12)
            return $urandom_range(10, 150);
        else if (r < 15)
            return $urandom_range(100, 1100);
        else
            return $urandom;
    endfunction

    // receiver side: random back-pressure bursts
    always @(posedge aclk) begin
        if (calm || stall_pct == 0) begin
            m_ready    <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frame_results_due.size() == 0) begin
                report_mismatch("result with no request due", m_clamped_elapsed_ms, '0);
            end else begin
                due_now = frame_results_due.pop_front();
                if (m_clamped_elapsed_ms !== due_now.clamped)
                    report_mismatch("clamped_elapsed_ms", m_clamped_elapsed_ms,
                                    due_now.clamped);
                if (m_wait_ms !== due_now.pause)
                    report_mismatch("wait_ms", {22'd0, m_wait_ms}, {22'd0, due_now.pause});
            end
        end
    end

    initial begin
        int                sent;
        int                next_mood;
        int                pick;
        int                n;
        logic [DATA_W-1:0] tick;

        // reset-state period of 100, mean 100, tick 0
        plan_known(ACT_UPDATE, 32'd5, 32'd10, 10'd90);
        plan_known(ACT_START, 32'hFFFF_FFFF, 32'd0, 10'd0);
        plan_known(ACT_UPDATE, 32'd49, 32'd50, 10'd50);        // elapsed across the wrap
        plan_known(ACT_UPDATE, 32'd249, 32'd100, 10'd0);       // ceiling clamp
        plan_known(ACT_START, 32'd0, 32'd0, 10'd0);
        plan_known(ACT_UPDATE, 32'hFFFF_FFFF, 32'd100, 10'd0); // mean wraps to 9
        plan_frame(ACT_UPDATE, 32'd49);
        plan_frame(ACT_UPDATE, 32'd52);                        // floor above the mean
        plan_frame(ACT_UPDATE, 32'd0);
        plan_period(10'd1);
        plan_known(ACT_START, 32'h1234_5678, 32'd0, 10'd0);
        plan_known(ACT_UPDATE, 32'h1234_5678, 32'd10, 10'd0);  // wait saturates
        plan_frame(ACT_UPDATE, 32'h1234_567D);
        plan_frame(ACT_UPDATE, 32'h1234_6000);
        plan_period(10'd1000);
        plan_frame(ACT_UPDATE, 32'h1234_6014);                 // new period, old mean
        plan_known(ACT_START, 32'hAAAA_AAAA, 32'd0, 10'd0);
        plan_known(ACT_UPDATE, 32'h5555_5555, 32'd1000, 10'd0);
        plan_known(ACT_START, 32'h5555_5555, 32'd0, 10'd0);
        plan_frame(ACT_UPDATE, 32'h5555_593C);
        plan_period(10'd100);
        plan_frame(ACT_START, 32'hFFFF_FF00);
        plan_frame(ACT_UPDATE, 32'hFFFF_FF64);
        plan_frame(ACT_UPDATE, 32'h0000_0010);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (pacing_plan[i]) begin
            if (pacing_plan[i].is_cfg) begin
                drain_results();
                write_period(pacing_plan[i].period);
            end else begin
                send_frame(pacing_plan[i].act, pacing_plan[i].now,
                           pacing_plan[i].known, pacing_plan[i].res);
            end
        end

        sent      = 0;
        next_mood = 0;
        tick      = $urandom;
        while (sent < RANDOM_FRAMES) begin
            if (sent >= RANDOM_FRAMES - CALM_FRAMES)
                calm = 1'b1;
            if (sent >= next_mood) begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 15;
                    default: stall_pct = 40;
                endcase
                next_mood += 100;
            end
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                // well-formed pacing run: start, then a stream of updates
                tick = $urandom;
                send_frame(ACT_START, tick, 1'b0, '0);
                n = $urandom_range(4, 60);
                for (int k = 0; k < n; k++) begin
                    tick = tick + frame_step();
                    send_frame(ACT_UPDATE, tick, 1'b0, '0);
                end
                sent += n + 1;
            end else if (pick < 17) begin
                n = $urandom_range(1, 5);
                repeat (n) send_frame(logic'($urandom_range(0, 1)), $urandom, 1'b0, '0);
                sent += n;
            end else if (pick < 19) begin
                // updates carrying on from wherever the last request left off
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++) begin
                    tick = tick + frame_step();
                    send_frame(ACT_UPDATE, tick, 1'b0, '0);
                end
                sent += n;
            end else begin
                drain_results();
                case ($urandom_range(0, 3))
                    0:       write_period(10'd1);
                    1:       write_period(10'd1000);
                    2:       write_period(PERIOD_W'($urandom_range(1, 15)));
                    default: write_period(PERIOD_W'($urandom_range(1, 1000)));
                endcase
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
